FILE: design/esch_pkg.sv
// Package for the epoch-stamped coordinate hash set.
// Holds the table geometry, the action codes, the mixer constants and the shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esch_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int KEY_W       = 64;
   localparam int COORD_W     = 32;
   localparam int EPOCH_W     = 32;
   localparam int ACTION_W    = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 32'd1;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MUL1,
      ST_SUM1,
      ST_MUL2,
      ST_SUM2,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] stamp;
      logic [KEY_W-1:0]   key;
   } slot_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [SLOT_W-1:0] addr;
      slot_type          wdata;
   } ram_req_type;

endpackage

`default_nettype wire

FILE: design/esch_req_if.sv
// Request channel of the coordinate hash set: one word per insert, query or clear.
// Depends on esch_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface esch_req_if;
   import esch_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [COORD_W-1:0]  x_coord;
   logic signed [COORD_W-1:0]  y_coord;

   modport source (output valid, output action, output x_coord, output y_coord,
                   input ready);
   modport sink   (input valid, input action, input x_coord, input y_coord,
                   output ready);
endinterface

`default_nettype wire

FILE: design/esch_rsp_if.sv
// Response channel of the coordinate hash set: one word per request.
// Depends on esch_pkg for nothing but kept alongside the request channel.
`timescale 1ns / 1ps
`default_nettype none

interface esch_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic table_full;

   modport source (output valid, output found, output table_full, input ready);
   modport sink   (input valid, input found, input table_full, output ready);
endinterface

`default_nettype wire

FILE: design/epoch_stamped_coordinate_hash_set_unit.sv
// Top level of the epoch-stamped coordinate hash set.
// Depends on esch_pkg, esch_req_if, esch_rsp_if and esch_slot_ram.
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing set of signed 2-D grid positions over TABLE_SLOTS slots. Each request
// word inserts a position, asks whether it is present, or clears the set; each request
// gives exactly one response word. The position {x, y} is hashed with the splitmix64
// finalizer, computed on one shared set of 32x32 multipliers in the states MUL1, SUM1,
// MUL2 and SUM2, and the low hash bits pick the home slot. Probing then walks the
// single-port slot memory one slot per cycle, because every probe needs the registered
// read of the previous one. An insert or query runs through the hash states, then one
// probe per slot visited, up to TABLE_SLOTS probes on a full table, then DONE. Clear and
// the unused action code go straight from IDLE to DONE. Items are handled one at a time;
// the response sits in an output register, so the next request is accepted while the
// previous word waits. A slot is live only when its stamp equals the current epoch, so
// clear just bumps the epoch. After reset, and after a clear that wraps the epoch to
// zero, a clearing pass writes zero to every slot in turn while req_ch.ready stays low.

module epoch_stamped_coordinate_hash_set_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   esch_req_if.sink    req_ch,
   esch_rsp_if.source  rsp_ch
);
   import esch_pkg::*;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

   // Control state.
   state_type          state_ff,     state_in;
   logic [SLOT_W-1:0]  pos_ff,       pos_in;
   logic [EPOCH_W-1:0] epoch_ff,     epoch_in;
   logic               wrap_ff,      wrap_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [ACTION_W-1:0] action_ff,   action_in;
   logic [KEY_W-1:0]    key_ff,      key_in;
   logic [KEY_W-1:0]    mix_ff,      mix_in;
   logic [KEY_W-1:0]    p0_ff,       p0_in;
   logic [31:0]         p1_ff,       p1_in;
   logic [31:0]         p2_ff,       p2_in;
   logic [SLOT_W-1:0]   cnt_ff,      cnt_in;
   logic                found_ff,    found_in;
   logic                full_ff,     full_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_full_ff,  rsp_full_in;

   logic [KEY_W-1:0]    mul_const;
   logic [KEY_W-1:0]    mul_sum;
   logic [KEY_W-1:0]    hash;
   logic [EPOCH_W-1:0]  epoch_inc;
   logic                accept;
   logic                rsp_load;

   ram_req_type ram_req;
   slot_type    rd_data;

   esch_slot_ram u_slot_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign accept = req_ch.valid && req_ch.ready;

   // Low 64 bits of a 64x64 product, built from three 32x32 partial products that are
   // registered in the MUL states and summed in the SUM states.
   assign mul_const = (state_ff == ST_MUL2) ? MIX_C2 : MIX_C1;
   assign p0_in     = {32'h0, mix_ff[31:0]} * {32'h0, mul_const[31:0]};
   assign p1_in     = mix_ff[31:0] * mul_const[63:32];
   assign p2_in     = mix_ff[63:32] * mul_const[31:0];
   assign mul_sum   = p0_ff + {32'(p1_ff + p2_ff), 32'h0};
   assign hash      = mul_sum ^ (mul_sum >> 31);
   assign epoch_inc = epoch_ff + EPOCH_FIRST;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      epoch_in     = epoch_ff;
      wrap_in      = wrap_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      mix_in       = mix_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      rsp_load     = 1'b0;
      req_ch.ready = 1'b0;
      ram_req      = '{rd_en: 1'b0, wr_en: 1'b0, addr: pos_ff, wdata: '0};

      unique case (state_ff)
         ST_SWEEP: begin
            // Zero every stamp; the key half is don't-care but written too.
            ram_req.wr_en = 1'b1;
            pos_in        = pos_ff + 1'b1;
            if (pos_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Ready is high throughout this state, so valid alone means a word is taken.
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               action_in = req_ch.action;
               key_in    = {req_ch.x_coord, req_ch.y_coord};
               mix_in    = {req_ch.x_coord, req_ch.y_coord}
                           ^ ({req_ch.x_coord, req_ch.y_coord} >> 30);
               found_in  = 1'b0;
               full_in   = 1'b0;
               wrap_in   = 1'b0;
               priority if (req_ch.action == ACT_INSERT || req_ch.action == ACT_QUERY) begin
                  state_in = ST_MUL1;
               end else if (req_ch.action == ACT_CLEAR) begin
                  state_in = ST_DONE;
                  if (epoch_inc == '0) begin
                     epoch_in = EPOCH_FIRST;
                     wrap_in  = 1'b1;
                  end else begin
                     epoch_in = epoch_inc;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL1: begin
            state_in = ST_SUM1;
         end
         ST_SUM1: begin
            mix_in   = mul_sum ^ (mul_sum >> 27);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_SUM2;
         end
         ST_SUM2: begin
            // Home slot: read it now, examine it next cycle.
            pos_in        = hash[SLOT_W-1:0];
            cnt_in        = '0;
            ram_req.rd_en = 1'b1;
            ram_req.addr  = hash[SLOT_W-1:0];
            state_in      = ST_PROBE;
         end
         ST_PROBE: begin
            priority if (rd_data.stamp != epoch_ff) begin
               // Free slot ends the probe; an insert claims it.
               if (action_ff == ACT_INSERT) begin
                  ram_req.wr_en = 1'b1;
                  ram_req.wdata = '{stamp: epoch_ff, key: key_ff};
               end
               state_in = ST_DONE;
            end else if (rd_data.key == key_ff) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (cnt_ff == SLOT_LAST) begin
               // Swept the whole table without a free slot.
               full_in  = (action_ff == ACT_INSERT);
               state_in = ST_DONE;
            end else begin
               pos_in        = pos_ff + 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               ram_req.rd_en = 1'b1;
               ram_req.addr  = pos_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               if (wrap_ff) begin
                  pos_in   = '0;
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_full_in  = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         pos_ff       <= '0;
         epoch_ff     <= EPOCH_FIRST;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         epoch_ff     <= epoch_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      key_ff       <= key_in;
      mix_ff       <= mix_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.table_full = rsp_full_ff;

   // A position is never reported both present and as overflowing the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.found && rsp_ch.table_full))
      else $error("found and table_full both set in one response word");

   // Epoch zero would make every cleared stamp look live.
   assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("epoch reached zero");

   // A probe that continues moves exactly one slot forward.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && state_in == ST_PROBE)
      |=> pos_ff == SLOT_W'($past(pos_ff) + 1'b1))
      else $error("probe did not advance by one slot");

   // A finished result waits while the previous response word is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_ch.valid && !rsp_ch.ready) |=> state_ff == ST_DONE)
      else $error("result left before the output register was free");

   // No request is taken while the slot memory is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> !accept)
      else $error("request accepted during the clearing pass");

endmodule

`default_nettype wire

FILE: design/esch_slot_ram.sv
// Single-port slot memory: one stamp and one key per slot, registered read.
// Depends on esch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esch_slot_ram (
   input  wire logic                 clock,
   input  wire esch_pkg::ram_req_type ram_req,
   output esch_pkg::slot_type         rd_data
);
   import esch_pkg::*;

   slot_type slot_mem [TABLE_SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         slot_mem[ram_req.addr] <= ram_req.wdata;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= slot_mem[ram_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking bench for epoch_stamped_coordinate_hash_set_unit: inserts, queries and
// clears of grid positions are checked against a slot-accurate model of the probing set.
// Depends on esch_pkg, esch_req_if, esch_rsp_if and the unit itself.
`timescale 1ns / 1ps

// Tracks the set as the unit should see it and holds the answers still owed.
class coord_set_scoreboard;
   typedef struct packed {
      logic found;
      logic table_full;
   } answer_type;

   logic [esch_pkg::KEY_W-1:0]   keys   [esch_pkg::TABLE_SLOTS];
   logic [esch_pkg::EPOCH_W-1:0] stamps [esch_pkg::TABLE_SLOTS];
   logic [esch_pkg::EPOCH_W-1:0] epoch;
   answer_type                   pending_answers[$];
   int errors;
   int words_checked;
   int hit_count;
   int full_count;
   int clear_count;

   function new();
      foreach (stamps[i]) begin
         stamps[i] = '0;
         keys[i]   = '0;
      end
      epoch         = esch_pkg::EPOCH_FIRST;
      errors        = 0;
      words_checked = 0;
      hit_count     = 0;
      full_count    = 0;
      clear_count   = 0;
   endfunction

   function logic [63:0] splitmix_finish(logic [63:0] v);
      v = v ^ (v >> 30);
      v = v * esch_pkg::MIX_C1;
      v = v ^ (v >> 27);
      v = v * esch_pkg::MIX_C2;
      v = v ^ (v >> 31);
      return v;
   endfunction

   // Applies one accepted request word to the set and queues the answer it must give.
   function void note_request(logic [1:0] action, logic [31:0] x, logic [31:0] y);
      logic [63:0]                  key;
      logic [63:0]                  hash;
      logic [esch_pkg::SLOT_W-1:0]  pos;
      answer_type                   ans;
      bit                           hit;
      bit                           has_free;
      int                           n;
      key      = {x, y};
      ans      = '0;
      hit      = 1'b0;
      has_free = 1'b0;
      if (action == esch_pkg::ACT_INSERT || action == esch_pkg::ACT_QUERY) begin
         hash = splitmix_finish(key);
         pos  = hash[esch_pkg::SLOT_W-1:0];
         // Walk at most one full sweep; pos stays on the first free slot.
         for (n = 0; n < esch_pkg::TABLE_SLOTS && !hit && !has_free; n++) begin
            if (stamps[pos] != epoch)
               has_free = 1'b1;
            else if (keys[pos] == key)
               hit = 1'b1;
            else
               pos = pos + 1'b1;
         end
         ans.found = hit;
         if (action == esch_pkg::ACT_INSERT && !hit) begin
            if (has_free) begin
               keys[pos]   = key;
               stamps[pos] = epoch;
            end else begin
               ans.table_full = 1'b1;
            end
         end
      end else if (action == esch_pkg::ACT_CLEAR) begin
         epoch = epoch + 1'b1;
         if (epoch == '0) begin
            foreach (stamps[i]) stamps[i] = '0;
            epoch = esch_pkg::EPOCH_FIRST;
         end
      end
      pending_answers.push_back(ans);
   endfunction

   function void check_result(logic found, logic table_full);
      answer_type want;
      if (pending_answers.size() == 0) begin
         $error("response word with no request outstanding: found=%0b table_full=%0b",
                found, table_full);
         errors++;
         return;
      end
      want = pending_answers.pop_front();
      words_checked++;
      if (found !== want.found) begin
         $error("found: expected %0b, got %0b", want.found, found);
         errors++;
      end
      if (table_full !== want.table_full) begin
         $error("table_full: expected %0b, got %0b", want.table_full, table_full);
         errors++;
      end
      if (want.found) hit_count++;
      if (want.table_full) full_count++;
   endfunction
endclass

module tb_top;
   import esch_pkg::*;

   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int MIXED_WORDS  = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int POOL_MAX     = 256;
   localparam int LOAD_WORDS   = 96;

   // Action code that the unit answers without touching the set.
   localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   rsp_hold_cycles;
   int   cycle_count;
   int   request_count;

   // Positions inserted since the last clear, kept so that queries and repeat inserts
   // mostly land on live entries.
   logic [63:0] live_pool[$];

   coord_set_scoreboard sb = new();

   esch_req_if req_ch ();
   esch_rsp_if rsp_ch ();

   epoch_stamped_coordinate_hash_set_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the normal run is far below this limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
   end

   // Receiver: stalls at random, or holds off completely while a hold count runs down.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Both handshakes are observed at the rising edge, where the inputs driven at the
   // falling edge are long settled.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_request(req_ch.action, req_ch.x_coord, req_ch.y_coord);
         request_count++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.found, rsp_ch.table_full);
   end

   // Offers one request word and returns at the edge where it is taken.
   task automatic send_word(input logic [ACTION_W-1:0] action, input logic [31:0] x,
                            input logic [31:0] y);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.action  = action;
      req_ch.x_coord = x;
      req_ch.y_coord = y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (action == ACT_CLEAR)
         live_pool.delete();
      else if (action == ACT_INSERT && live_pool.size() < POOL_MAX)
         live_pool.push_back({x, y});
   endtask

   // Stops offering and waits until every owed response word has been checked.
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] corner_coord();
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0001;
         default: return 32'h0000_0000;
      endcase
   endfunction

   // Random position: a live one, a tiny neighborhood that repeats often, anything at
   // all, or a corner of the coordinate range.
   task automatic pick_position(output logic [31:0] x, output logic [31:0] y);
      int          style;
      logic [63:0] pair;
      style = $urandom_range(0, 99);
      if (style < 30 && live_pool.size() != 0) begin
         pair = live_pool[$urandom_range(0, live_pool.size() - 1)];
         x    = pair[63:32];
         y    = pair[31:0];
      end else if (style < 60) begin
         x = $urandom_range(0, 6) - 3;
         y = $urandom_range(0, 6) - 3;
      end else if (style < 90) begin
         x = $urandom();
         y = $urandom();
      end else begin
         x = corner_coord();
         y = corner_coord();
      end
   endtask

   task automatic send_mixed(input int count);
      int          i;
      int          roll;
      logic [31:0] x;
      logic [31:0] y;
      for (i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         pick_position(x, y);
         if (roll < 45)
            send_word(ACT_INSERT, x, y);
         else if (roll < 94)
            send_word(ACT_QUERY, x, y);
         else if (roll < 97)
            send_word(ACT_CLEAR, x, y);
         else
            send_word(ACT_NOP, x, y);
      end
   endtask

   task automatic send_directed();
      logic [31:0] lo;
      logic [31:0] hi;
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
      send_word(ACT_INSERT, 32'd0, 32'd0);
      send_word(ACT_INSERT, 32'd0, 32'd0);      // duplicate
      send_word(ACT_QUERY,  32'd0, 32'd0);
      send_word(ACT_QUERY,  32'd1, 32'd0);      // miss
      send_word(ACT_INSERT, lo, lo);
      send_word(ACT_INSERT, hi, hi);
      send_word(ACT_INSERT, lo, hi);
      send_word(ACT_INSERT, hi, lo);
      send_word(ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      send_word(ACT_QUERY,  lo, lo);
      send_word(ACT_QUERY,  hi, hi);
      send_word(ACT_QUERY,  hi, lo);
      send_word(ACT_QUERY,  32'hffff_ffff, 32'hffff_ffff);
      send_word(ACT_QUERY,  lo, 32'hffff_ffff);  // miss near a live key
      send_word(ACT_NOP, $urandom(), $urandom());  // unused action
      send_word(ACT_CLEAR, 32'd0, 32'd0);
      send_word(ACT_QUERY,  32'd0, 32'd0);      // gone after clear
      send_word(ACT_QUERY,  hi, hi);
      send_word(ACT_INSERT, 32'd0, 32'd0);
      send_word(ACT_QUERY,  32'd0, 32'd0);
   endtask

   // Loads a fresh epoch with a block of positions, then checks hits, misses and repeat
   // inserts that probe past the loaded entries.
   task automatic load_epoch();
      int i;
      send_word(ACT_CLEAR, 32'd0, 32'd0);
      for (i = 0; i < LOAD_WORDS; i++)
         send_word(ACT_INSERT, 32'h4000_0000 + i, 32'h1357_9bdf);
      send_word(ACT_QUERY,  32'hffff_fff9, 32'd99999);          // miss
      send_word(ACT_INSERT, 32'h4000_0005, 32'h1357_9bdf);      // duplicate
      send_word(ACT_QUERY,  32'h4000_0000 + LOAD_WORDS - 1, 32'h1357_9bdf);
      send_word(ACT_INSERT, 32'hffff_fff9, 32'd99999);
      send_word(ACT_QUERY,  32'hffff_fff9, 32'd99999);
      send_word(ACT_NOP, 32'd0, 32'd0);
      send_word(ACT_CLEAR, 32'd0, 32'd0);
      send_word(ACT_QUERY,  32'h4000_0005, 32'h1357_9bdf);      // gone after clear
   endtask

   initial begin
      int idle_plan  [4];
      int stall_plan [4];
      int p;
      int i;
      idle_plan       = '{0, 59, 0, 15};
      stall_plan      = '{0, 0, 59, 15};
      reset           = 1'b1;
      idle_pct        = 0;
      stall_pct       = 0;
      rsp_hold_cycles = 0;
      request_count   = 0;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_INSERT;
      req_ch.x_coord  = '0;
      req_ch.y_coord  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The unit runs its clearing pass first; send_word simply waits for ready.
      send_directed();
      drain();

      for (p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         send_mixed(MIXED_WORDS);
         drain();
         if (p == 0) begin
            // Long receiver hold-off while the sender keeps offering: the output
            // register and the engine fill up and request ready must drop.
            rsp_hold_cycles = HOLD_CYCLES;
            for (i = 0; i < 30; i++) begin
               send_word(($urandom_range(0, 1) != 0) ? ACT_INSERT : ACT_QUERY,
                         $urandom_range(0, 4), $urandom_range(0, 4));
            end
            drain();
         end
      end

      idle_pct  = 15;
      stall_pct = 15;
      load_epoch();
      drain();
      repeat (20) @(posedge clock);

      $display("run covered %0d request words and %0d checked responses",
               request_count, sb.words_checked);
      $display("answers seen: %0d found, %0d table full, %0d leftover",
               sb.hit_count, sb.full_count, sb.pending_answers.size());
      if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
